// File: src/sum_of_two_squares_count_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lattice point counter
// Shared forms for the concurrent checks of the counter's modules.
// ----------------------------------------------------------------------------
`ifndef SUM_OF_TWO_SQUARES_COUNT_TOP_ASSERT_SVH
`define SUM_OF_TWO_SQUARES_COUNT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sots assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SOTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sots assertion failed");

`endif

// File: src/sots_pkg.sv
// ----------------------------------------------------------------------------
// sots_pkg
// Widths, controller states and the command and status bundles of the
// lattice point counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sots_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int DIV_W       = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int BIT_W       = $clog2(VALUE_WIDTH);
  localparam int EXP_W       = $clog2(VALUE_WIDTH);
  localparam int FAC_W       = EXP_W + 1;
  localparam int OUT_W       = 16;
  localparam int COUNT_W     = OUT_W - 1;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(1) << (OUT_W - 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_CHECK,
    S_FINISH
  } sots_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic take_quot;
    logic next_div;
    logic finish;
  } sots_cmd_t;

  typedef struct packed {
    logic div_last;
    logic over;
    logic rem_zero;
    logic first_test;
    logic out_free;
  } sots_status_t;

endpackage

`default_nettype wire

// File: src/sots_if.sv
// ----------------------------------------------------------------------------
// sots_if
// Valid/ready channels that carry the input and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sots_in_if;
  import sots_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] radius_squared;

  modport source (output valid, output radius_squared, input ready);
  modport sink (input valid, input radius_squared, output ready);
endinterface

interface sots_out_if;
  import sots_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] point_count;

  modport source (output valid, output point_count, input ready);
  modport sink (input valid, input point_count, output ready);
endinterface

`default_nettype wire

// File: src/sum_of_two_squares_count_top.sv
// The block counts the integer points on the circle x*x + y*y = n for each
// word n on the input channel and returns one count per word, 0 for n = 0.
// It factors n by trial division with a shift-subtract divider that retires
// one quotient bit per cycle, and the divisors run over 2 and the odd
// numbers up to the square root of the remaining cofactor. One word is
// worked on at a time, and the next word is taken while the previous count
// still waits in the output register.
// ----------------------------------------------------------------------------
// sum_of_two_squares_count_top
// Lattice point counter on a circle by the two-square theorem.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sum_of_two_squares_count_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sots_in_if.sink    in_ch,
  sots_out_if.source out_ch
);
  import sots_pkg::*;

  sots_cmd_t    cmd;
  sots_status_t status;

  sots_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sots_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_ch.radius_squared),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.point_count)
  );

endmodule

`default_nettype wire

// File: src/sots_datapath.sv
// ----------------------------------------------------------------------------
// sots_datapath
// Trial divisor, shift-subtract divider, exponent count, running product of
// the prime power factors and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sots_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sots_pkg::sots_cmd_t             cmd,
  output sots_pkg::sots_status_t               status,
  input  wire logic [sots_pkg::VALUE_WIDTH-1:0] in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [sots_pkg::OUT_W-1:0]           out_data
);
  import sots_pkg::*;

  logic [VALUE_WIDTH-1:0]     n_r, n_nxt;
  logic [DIV_W-1:0]           d_r, d_nxt;
  logic [DIV_W-1:0]           rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0]     quo_r, quo_nxt;
  logic [BIT_W-1:0]           bit_r, bit_nxt;
  logic [EXP_W-1:0]           e_r, e_nxt;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic                       sat_r, sat_nxt;
  logic                       zero_r, zero_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]           out_data_r, out_data_nxt;

  logic [DIV_W:0]             shifted;
  logic [DIV_W:0]             diff;
  logic                       ge;
  logic [FAC_W-1:0]           fac;
  logic [COUNT_W+FAC_W-1:0]   prod;
  logic [COUNT_W:0]           fin_count;
  logic                       fin_zero;
  logic                       fin_sat;

  assign shifted = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, d_r};
  assign ge      = shifted >= {1'b0, d_r};

  // A prime of the form 4k+1 gives a factor e+1, one of the form 4k+3 a factor
  // 1 for an even exponent and 0 for an odd one, and two a factor 1.
  always_comb begin
    unique case (d_r[1:0])
      2'b01:   fac = FAC_W'(e_r) + FAC_W'(1);
      2'b11:   fac = e_r[0] ? '0 : FAC_W'(1);
      default: fac = FAC_W'(1);
    endcase
  end

  assign prod = (COUNT_W+FAC_W)'(count_r) * (COUNT_W+FAC_W)'(fac);

  // The cofactor left over after the last trial divisor is 1 or a prime.
  always_comb begin
    fin_zero  = zero_r;
    fin_count = {1'b0, count_r};
    if (n_r > VALUE_WIDTH'(1)) begin
      unique case (n_r[1:0])
        2'b11:   fin_zero  = 1'b1;
        2'b01:   fin_count = {count_r, 1'b0};
        default: fin_count = {1'b0, count_r};
      endcase
    end
    fin_sat = sat_r || (fin_count >= {1'b0, COUNT_CAP});
  end

  assign status.div_last   = bit_r == BIT_W'(VALUE_WIDTH - 1);
  assign status.over       = VALUE_WIDTH'(d_r) > quo_r;
  assign status.rem_zero   = rem_r == '0;
  assign status.first_test = e_r == '0;
  assign status.out_free   = !out_valid_r || out_ready;

  always_comb begin
    n_nxt         = n_r;
    d_nxt         = d_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    bit_nxt       = bit_r;
    e_nxt         = e_r;
    count_nxt     = count_r;
    sat_nxt       = sat_r;
    zero_nxt      = zero_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      n_nxt     = in_data;
      d_nxt     = DIV_W'(2);
      e_nxt     = '0;
      count_nxt = COUNT_W'(1);
      sat_nxt   = 1'b0;
      zero_nxt  = in_data == '0;
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
      quo_nxt = n_r;
      bit_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], ge};
      bit_nxt = bit_r + BIT_W'(1);
    end
    if (cmd.take_quot) begin
      n_nxt = quo_r;
      e_nxt = e_r + EXP_W'(1);
    end
    if (cmd.next_div) begin
      if (e_r != '0) begin
        if (fac == '0) begin
          zero_nxt = 1'b1;
        end else if (!sat_r) begin
          if (prod > (COUNT_W+FAC_W)'(COUNT_CAP)) begin
            sat_nxt = 1'b1;
          end else begin
            count_nxt = prod[COUNT_W-1:0];
          end
        end
      end
      d_nxt = (d_r == DIV_W'(2)) ? DIV_W'(3) : d_r + DIV_W'(2);
      e_nxt = '0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (fin_zero) begin
        out_data_nxt = '0;
      end else if (fin_sat) begin
        out_data_nxt = '1;
      end else begin
        out_data_nxt = {fin_count[COUNT_W-2:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    bit_r      <= bit_nxt;
    e_r        <= e_nxt;
    count_r    <= count_nxt;
    sat_r      <= sat_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: src/sots_ctrl.sv
// ----------------------------------------------------------------------------
// sots_ctrl
// Sequencer that runs one division per trial divisor and per repeated
// division by it, and steps through the factorization of the accepted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sum_of_two_squares_count_top_assert.svh"

module sots_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire sots_pkg::sots_status_t status,
  output sots_pkg::sots_cmd_t         cmd
);
  import sots_pkg::*;

  sots_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // A new divisor above the square root ends the search; a divisor
        // already known to divide keeps being removed.
        priority if (status.first_test && status.over) begin
          state_nxt = S_FINISH;
        end else if (status.rem_zero) begin
          cmd.take_quot = 1'b1;
          state_nxt     = S_START;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = S_START;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `SOTS_ASSERT_NEXT(a_div_ends_in_check, clk, rst_n, state_r == S_DIV && status.div_last, state_r == S_CHECK)
  `SOTS_ASSERT_NOW(a_finish_has_slot, clk, rst_n, cmd.finish, status.out_free)
  `SOTS_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == S_START)

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lattice point counter. A small scoreboard
// computes r2(n) by its own trial division for every accepted radius word
// and checks each returned count in order. Stimulus starts with edge values
// and then runs random small values and random smooth numbers that reach
// the full input width, under three settings of sender and receiver gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sots_pkg::*;

  localparam int STALL_LIMIT = 3000000;
  localparam int RANDOM_PER_PHASE = 26;
  localparam int unsigned SMALL_PRIMES [16] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53
  };
  localparam longint unsigned EDGE_RADII [22] = '{
    0, 1, 2, 3, 4, 5, 9, 21, 25, 26, 65, 325, 1105, 53361,
    48612265, 1555592480, 387420489, 1162261467, 1220703125,
    1073741824, 2147483646, 2147483647
  };

  class lattice_scoreboard;
    logic [OUT_W-1:0] pending_counts [$];
    int unsigned      mismatches;
    int unsigned      radii_seen;
    int unsigned      counts_checked;

    function new();
      mismatches     = 0;
      radii_seen     = 0;
      counts_checked = 0;
    endfunction

    function logic [OUT_W-1:0] count_lattice_points(logic [VALUE_WIDTH-1:0] radius);
      longint unsigned m;
      longint unsigned d;
      longint unsigned count;
      longint unsigned total;
      int unsigned     e;
      bit              zero;
      m = radius;
      if (m == 0) return '0;
      if (m == 1) return OUT_W'(4);
      count = 1;
      zero  = 1'b0;
      for (d = 2; d <= m / d; d++) begin
        if (m % d == 0) begin
          e = 0;
          while (m % d == 0) begin
            m = m / d;
            e++;
          end
          if (d % 4 == 1) begin
            count = count * (e + 1);
            if (count > longint'(COUNT_CAP)) count = longint'(COUNT_CAP) + 1;
          end else if (d % 4 == 3 && e % 2 == 1) begin
            zero = 1'b1;
          end
        end
      end
      if (m > 1) begin
        if (m % 4 == 1) begin
          count = count * 2;
          if (count > longint'(COUNT_CAP)) count = longint'(COUNT_CAP) + 1;
        end else if (m % 4 == 3) begin
          zero = 1'b1;
        end
      end
      if (zero) return '0;
      total = 4 * count;
      if (total > 65535) total = 65535;
      return OUT_W'(total);
    endfunction

    function void note_radius(logic [VALUE_WIDTH-1:0] radius);
      pending_counts = {pending_counts, count_lattice_points(radius)};
      radii_seen++;
    endfunction

    function void check_count(logic [OUT_W-1:0] actual);
      logic [OUT_W-1:0] want;
      counts_checked++;
      if (pending_counts.size() == 0) begin
        $error("point_count: expected none, actual %0d", actual);
        mismatches++;
        return;
      end
      want = pending_counts.pop_front();
      if (actual !== want) begin
        $error("point_count: expected %0d, actual %0d", want, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  int   stall_cycles;
  lattice_scoreboard sb;

  sots_in_if  in_bus ();
  sots_out_if out_bus ();

  sum_of_two_squares_count_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) sb.note_radius(in_bus.radius_squared);
      if (out_bus.valid && out_bus.ready) sb.check_count(out_bus.point_count);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles.", stall_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic longint unsigned draw_radius();
    longint unsigned n;
    longint unsigned f;
    longint unsigned p;
    int              limit_bits;
    int              k;
    n = 1;
    if ($urandom_range(9) < 4) return longint'($urandom_range(0, 4095));
    limit_bits = $urandom_range(1, VALUE_WIDTH);
    for (k = 0; k < 40; k++) begin
      p = SMALL_PRIMES[$urandom_range(0, 15)];
      f = (p % 4 == 3 && $urandom_range(1) == 1) ? p * p : p;
      if (n * f >= (64'd1 << limit_bits)) break;
      n = n * f;
    end
    if ($urandom_range(2) == 0) begin
      f = $urandom_range(1, 4095);
      if (n * f < (64'd1 << VALUE_WIDTH)) n = n * f;
    end
    return n;
  endfunction

  task automatic send_radius(input logic [VALUE_WIDTH-1:0] n);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.radius_squared <= n;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic send_random(input int words);
    int k;
    for (k = 0; k < words; k++) send_radius(VALUE_WIDTH'(draw_radius()));
  endtask

  initial begin
    sb                    = new();
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    stall_cycles          = 0;
    in_bus.valid          = 1'b0;
    in_bus.radius_squared = '0;
    out_bus.ready         = 1'b0;
    in_idle_pct           = 28;
    out_idle_pct          = 64;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (EDGE_RADII[k]) send_radius(VALUE_WIDTH'(EDGE_RADII[k]));
    send_random(RANDOM_PER_PHASE);

    in_idle_pct  = 64;
    out_idle_pct = 28;
    send_random(RANDOM_PER_PHASE);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_random(RANDOM_PER_PHASE);

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending_counts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d radius words (edge values, small and smooth random values).",
             sb.radii_seen);
    $display("Checked %0d point counts under three gap settings, %0d mismatches.",
             sb.counts_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
